// ===== sv/ham_pkg.sv =====
// Shared types, constants and helper functions for the HAM6/HAM8 pixel decoder.
package ham_pkg;

    localparam int PAL_DEPTH = 64;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int MAX_LINE  = 4096;
    localparam int SIZE_W    = 13;
    localparam int CNT_W     = 12;
    localparam int ADDR_W    = 24;
    localparam int RGB_W     = 24;
    localparam int CH_W      = 8;
    localparam int CODE_W    = 8;
    localparam int PCNT_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HAM8_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_HEIGHT = 3'd5;

    // Pixel control codes
    localparam logic [1:0] CTRL_PALETTE = 2'd0;
    localparam logic [1:0] CTRL_BLUE    = 2'd1;
    localparam logic [1:0] CTRL_RED     = 2'd2;
    localparam logic [1:0] CTRL_GREEN   = 2'd3;

    localparam logic CMD_PIXEL     = 1'b0;
    localparam logic CMD_PAL_WRITE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [CODE_W-1:0] pixel_code;
        logic [5:0]        palette_index;
        logic [RGB_W-1:0]  palette_rgb;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic              write_enable;
        logic [ADDR_W-1:0] pixel_addr;
    } t_out_item;

    // Decoded pixel handed from the input stage to the hold stage
    typedef struct packed {
        logic             valid;
        logic [1:0]       ctrl;
        logic [CH_W-1:0]  wide;
        logic             pal_hit;
        logic [RGB_W-1:0] pal_rgb;
    } t_dec;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_LINE)) begin
            r = SIZE_W'(MAX_LINE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CH_W-1:0] widen(input logic [5:0] d, input logic is8);
        logic [CH_W-1:0] r;
        if (is8) begin
            r = {d, d[5:4]};
        end else begin
            r = {d[3:0], d[3:0]};
        end
        return r;
    endfunction

endpackage

// ===== sv/ham_decode.sv =====
// Input stage: palette memory, code split into control and data, palette lookup.
module ham_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  ham_pkg::t_in_item             i_in_data,
    input  logic                          i_take,
    input  logic                          i_ham8_mode,
    input  logic [ham_pkg::PCNT_W-1:0]    i_palette_count,
    output ham_pkg::t_dec                 o_dec
);

    logic [ham_pkg::RGB_W-1:0] r_pal_mem [ham_pkg::PAL_DEPTH];
    logic [ham_pkg::RGB_W-1:0] r_pal_q;
    logic                      r_valid;
    logic [1:0]                r_ctrl;
    logic [ham_pkg::CH_W-1:0]  r_wide;
    logic                      r_pal_hit;

    logic [5:0]                  n_d;
    logic [1:0]                  n_ctrl;
    logic [ham_pkg::PCNT_W-1:0]  n_count;
    logic                        n_hit;

    always_comb begin
        if (i_ham8_mode) begin
            n_d    = i_in_data.pixel_code[5:0];
            n_ctrl = i_in_data.pixel_code[7:6];
        end else begin
            n_d    = {2'b00, i_in_data.pixel_code[3:0]};
            n_ctrl = i_in_data.pixel_code[5:4];
        end
        // saturate the entry count to the palette depth
        if (i_palette_count > ham_pkg::PCNT_W'(ham_pkg::PAL_DEPTH)) begin
            n_count = ham_pkg::PCNT_W'(ham_pkg::PAL_DEPTH);
        end else begin
            n_count = i_palette_count;
        end
        n_hit = {1'b0, n_d} < n_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_in_data.command == ham_pkg::CMD_PAL_WRITE) begin
            r_pal_mem[i_in_data.palette_index[ham_pkg::PAL_AW-1:0]] <= i_in_data.palette_rgb;
        end
        if (i_accept) begin
            r_pal_q <= r_pal_mem[n_d[ham_pkg::PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= (i_in_data.command == ham_pkg::CMD_PIXEL);
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ctrl    <= n_ctrl;
            r_wide    <= ham_pkg::widen(n_d, i_ham8_mode);
            r_pal_hit <= n_hit;
        end
    end

    assign o_dec.valid   = r_valid;
    assign o_dec.ctrl    = r_ctrl;
    assign o_dec.wide    = r_wide;
    assign o_dec.pal_hit = r_pal_hit;
    assign o_dec.pal_rgb = r_pal_q;

endmodule

// ===== sv/ham6_ham8_pixel_decoder.sv =====
// A pixel goes through the decode registers, then the output register.
// Throughput: one transaction per cycle unless the output stalls; the palette
// read and output registers form two stages, palette writes give no result.
// Reset (synchronous, active low) clears held color, column and row counters,
// pipeline valids and loads the register defaults; palette contents stay
// undefined until written.
module ham6_ham8_pixel_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ham_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ham_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ham_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ham_pkg::t_out_item              o_out_data
);

    logic                          r_ham8_mode;
    logic [ham_pkg::PCNT_W-1:0]    r_palette_count;
    logic [ham_pkg::SIZE_W-1:0]    r_line_width;
    logic [ham_pkg::SIZE_W-1:0]    r_frame_height;
    logic [ham_pkg::SIZE_W-1:0]    r_visible_width;
    logic [ham_pkg::SIZE_W-1:0]    r_visible_height;

    logic [ham_pkg::CH_W-1:0]      r_hold_red;
    logic [ham_pkg::CH_W-1:0]      r_hold_green;
    logic [ham_pkg::CH_W-1:0]      r_hold_blue;
    logic [ham_pkg::CNT_W-1:0]     r_col;
    logic [ham_pkg::CNT_W-1:0]     r_row;

    logic                          r_out_valid;
    ham_pkg::t_out_item            r_out;

    ham_pkg::t_dec                 dec;
    logic                          out_free;
    logic                          take;
    logic                          accept;

    logic [ham_pkg::CH_W-1:0]      n_red;
    logic [ham_pkg::CH_W-1:0]      n_green;
    logic [ham_pkg::CH_W-1:0]      n_blue;
    logic [ham_pkg::SIZE_W-1:0]    n_w;
    logic [ham_pkg::SIZE_W-1:0]    n_h;
    logic [ham_pkg::SIZE_W-1:0]    n_col_inc;
    logic [ham_pkg::SIZE_W-1:0]    n_row_inc;
    logic                          n_wrap;
    logic [ham_pkg::ADDR_W:0]      n_prod;
    logic [ham_pkg::ADDR_W-1:0]    n_addr;
    logic                          n_we;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign take       = dec.valid && out_free;
    assign o_in_stall = dec.valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    ham_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_data       (i_in_data),
        .i_take          (take),
        .i_ham8_mode     (r_ham8_mode),
        .i_palette_count (r_palette_count),
        .o_dec           (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ham8_mode      <= 1'b0;
            r_palette_count  <= '0;
            r_line_width     <= ham_pkg::SIZE_W'(16);
            r_frame_height   <= ham_pkg::SIZE_W'(16);
            r_visible_width  <= ham_pkg::SIZE_W'(16);
            r_visible_height <= ham_pkg::SIZE_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ham_pkg::CFG_HAM8_MODE:      r_ham8_mode      <= i_cfg_data[0];
                ham_pkg::CFG_PALETTE_COUNT:  r_palette_count  <= i_cfg_data[ham_pkg::PCNT_W-1:0];
                ham_pkg::CFG_LINE_WIDTH:     r_line_width     <= i_cfg_data;
                ham_pkg::CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data;
                ham_pkg::CFG_VISIBLE_WIDTH:  r_visible_width  <= i_cfg_data;
                ham_pkg::CFG_VISIBLE_HEIGHT: r_visible_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_red   = r_hold_red;
        n_green = r_hold_green;
        n_blue  = r_hold_blue;
        case (dec.ctrl)
            ham_pkg::CTRL_PALETTE: begin
                if (dec.pal_hit) begin
                    n_red   = dec.pal_rgb[23:16];
                    n_green = dec.pal_rgb[15:8];
                    n_blue  = dec.pal_rgb[7:0];
                end else begin
                    n_red   = '0;
                    n_green = '0;
                    n_blue  = '0;
                end
            end
            ham_pkg::CTRL_BLUE:  n_blue  = dec.wide;
            ham_pkg::CTRL_RED:   n_red   = dec.wide;
            ham_pkg::CTRL_GREEN: n_green = dec.wide;
            default: ;
        endcase

        n_w       = ham_pkg::clamp_size(r_line_width);
        n_h       = ham_pkg::clamp_size(r_frame_height);
        n_col_inc = {1'b0, r_col} + ham_pkg::SIZE_W'(1);
        n_row_inc = {1'b0, r_row} + ham_pkg::SIZE_W'(1);
        n_wrap    = n_col_inc >= n_w;
        n_prod    = {{(ham_pkg::ADDR_W + 1 - ham_pkg::CNT_W){1'b0}}, r_row}
                  * {{(ham_pkg::ADDR_W + 1 - ham_pkg::SIZE_W){1'b0}}, n_w};
        n_addr    = n_prod[ham_pkg::ADDR_W-1:0]
                  + {{(ham_pkg::ADDR_W - ham_pkg::CNT_W){1'b0}}, r_col};
        n_we      = ({1'b0, r_col} < r_visible_width) && ({1'b0, r_row} < r_visible_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_red   <= '0;
            r_hold_green <= '0;
            r_hold_blue  <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                // clear the held color at each row start
                if (n_wrap) begin
                    r_hold_red   <= '0;
                    r_hold_green <= '0;
                    r_hold_blue  <= '0;
                    r_col        <= '0;
                    if (n_row_inc >= n_h) begin
                        r_row <= '0;
                    end else begin
                        r_row <= n_row_inc[ham_pkg::CNT_W-1:0];
                    end
                end else begin
                    r_hold_red   <= n_red;
                    r_hold_green <= n_green;
                    r_hold_blue  <= n_blue;
                    r_col        <= n_col_inc[ham_pkg::CNT_W-1:0];
                end
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.red          <= n_red;
            r_out.green        <= n_green;
            r_out.blue         <= n_blue;
            r_out.write_enable <= n_we;
            r_out.pixel_addr   <= n_addr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_wrap_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && n_wrap |=> r_hold_red == '0 && r_hold_green == '0 && r_hold_blue == '0)
        else $error("held color not cleared at row wrap");

    a_take_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("decoded pixel lost before output register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall && dec.valid)
        else $error("input stalled while pipeline has room");

    a_col_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> {1'b0, r_col} < $past(n_w) || r_col == '0)
        else $error("column counter beyond line width");
`endif

endmodule

// ===== sim/ham6_ham8_pixel_decoder_tb.sv =====
// Self-checking testbench for the HAM6/HAM8 pixel decoder: palette, decode, raster address.
module ham6_ham8_pixel_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks held color, raster position, palette and registers; queues expected pixels.
    class ham_pixel_tracker;
        logic                       ham8;
        logic [ham_pkg::PCNT_W-1:0] pal_count;
        logic [ham_pkg::SIZE_W-1:0] line_w;
        logic [ham_pkg::SIZE_W-1:0] frame_h;
        logic [ham_pkg::SIZE_W-1:0] vis_w;
        logic [ham_pkg::SIZE_W-1:0] vis_h;
        logic [ham_pkg::CH_W-1:0]   hold_r;
        logic [ham_pkg::CH_W-1:0]   hold_g;
        logic [ham_pkg::CH_W-1:0]   hold_b;
        int unsigned                col;
        int unsigned                row;
        logic [ham_pkg::RGB_W-1:0]  pal_shadow [ham_pkg::PAL_DEPTH];
        ham_pkg::t_out_item         expected_pixels [$];
        int unsigned                mismatches;

        function new();
            ham8 = 1'b0;
            pal_count = '0;
            line_w = ham_pkg::SIZE_W'(16);
            frame_h = ham_pkg::SIZE_W'(16);
            vis_w = ham_pkg::SIZE_W'(16);
            vis_h = ham_pkg::SIZE_W'(16);
            hold_r = '0;
            hold_g = '0;
            hold_b = '0;
            col = 0;
            row = 0;
            mismatches = 0;
        endfunction

        function void set_register(logic [ham_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ham_pkg::CFG_DAT_W-1:0] value);
            case (idx)
                ham_pkg::CFG_HAM8_MODE:      ham8 = value[0];
                ham_pkg::CFG_PALETTE_COUNT:  pal_count = value[ham_pkg::PCNT_W-1:0];
                ham_pkg::CFG_LINE_WIDTH:     line_w = value[ham_pkg::SIZE_W-1:0];
                ham_pkg::CFG_FRAME_HEIGHT:   frame_h = value[ham_pkg::SIZE_W-1:0];
                ham_pkg::CFG_VISIBLE_WIDTH:  vis_w = value[ham_pkg::SIZE_W-1:0];
                ham_pkg::CFG_VISIBLE_HEIGHT: vis_h = value[ham_pkg::SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned effective_size(logic [ham_pkg::SIZE_W-1:0] v);
            if (v == '0) return 1;
            if (v > ham_pkg::SIZE_W'(ham_pkg::MAX_LINE)) return ham_pkg::MAX_LINE;
            return int'(v);
        endfunction

        function void accept_item(ham_pkg::t_in_item it);
            logic [5:0]                d;
            logic [1:0]                ctrl;
            logic [ham_pkg::CH_W-1:0]  wide;
            logic [ham_pkg::RGB_W-1:0] c;
            int unsigned               cnt;
            int unsigned               w;
            int unsigned               h;
            ham_pkg::t_out_item        px;
            if (it.command == ham_pkg::CMD_PAL_WRITE) begin
                pal_shadow[it.palette_index] = it.palette_rgb;
                return;
            end
            if (ham8) begin
                d = it.pixel_code[5:0];
                ctrl = it.pixel_code[7:6];
                wide = {d, d[5:4]};
            end else begin
                d = {2'b00, it.pixel_code[3:0]};
                ctrl = it.pixel_code[5:4];
                wide = {d[3:0], d[3:0]};
            end
            cnt = (pal_count > ham_pkg::PCNT_W'(ham_pkg::PAL_DEPTH)) ?
                  ham_pkg::PAL_DEPTH : int'(pal_count);
            case (ctrl)
                ham_pkg::CTRL_PALETTE: begin
                    if (int'(d) < cnt) begin
                        c = pal_shadow[d];
                        hold_r = c[23:16];
                        hold_g = c[15:8];
                        hold_b = c[7:0];
                    end else begin
                        hold_r = '0;
                        hold_g = '0;
                        hold_b = '0;
                    end
                end
                ham_pkg::CTRL_BLUE:  hold_b = wide;
                ham_pkg::CTRL_RED:   hold_r = wide;
                ham_pkg::CTRL_GREEN: hold_g = wide;
                default: ;
            endcase
            w = effective_size(line_w);
            h = effective_size(frame_h);
            px.red = hold_r;
            px.green = hold_g;
            px.blue = hold_b;
            px.write_enable = (col < int'(vis_w)) && (row < int'(vis_h));
            px.pixel_addr = ham_pkg::ADDR_W'(row * w + col);
            expected_pixels.push_back(px);
            // advance raster position; a row wrap clears the held color
            col = col + 1;
            if (col >= w) begin
                col = 0;
                hold_r = '0;
                hold_g = '0;
                hold_b = '0;
                row = row + 1;
                if (row >= h) row = 0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches = mismatches + 1;
        endtask

        task check_pixel(ham_pkg::t_out_item got);
            ham_pkg::t_out_item want;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel, addr %06h", got.pixel_addr));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red !== want.red)
                report_mismatch($sformatf("red %02h, want %02h", got.red, want.red));
            if (got.green !== want.green)
                report_mismatch($sformatf("green %02h, want %02h", got.green, want.green));
            if (got.blue !== want.blue)
                report_mismatch($sformatf("blue %02h, want %02h", got.blue, want.blue));
            if (got.write_enable !== want.write_enable)
                report_mismatch($sformatf("write_enable %b, want %b",
                                          got.write_enable, want.write_enable));
            if (got.pixel_addr !== want.pixel_addr)
                report_mismatch($sformatf("pixel_addr %06h, want %06h",
                                          got.pixel_addr, want.pixel_addr));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [ham_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ham_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    ham_pkg::t_in_item             i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    ham_pkg::t_out_item            o_out_data;

    ham_pixel_tracker tracker = new();
    logic             idle_on = 1'b0;
    int               stall_left = 0;

    ham6_ham8_pixel_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Output back-pressure in random bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (idle_on && stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall = 1'b1;
        end else begin
            stall_left = 0;
            i_out_stall = 1'b0;
            if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_pixel(o_out_data);
        end
    end

    function automatic ham_pkg::t_in_item pixel_item(logic [ham_pkg::CODE_W-1:0] code);
        ham_pkg::t_in_item it;
        it.command = ham_pkg::CMD_PIXEL;
        it.pixel_code = code;
        it.palette_index = 6'($urandom);
        it.palette_rgb = ham_pkg::RGB_W'($urandom);
        return it;
    endfunction

    function automatic ham_pkg::t_in_item palette_item(logic [5:0] idx,
                                                       logic [ham_pkg::RGB_W-1:0] rgb);
        ham_pkg::t_in_item it;
        it.command = ham_pkg::CMD_PAL_WRITE;
        it.pixel_code = ham_pkg::CODE_W'($urandom);
        it.palette_index = idx;
        it.palette_rgb = rgb;
        return it;
    endfunction

    task automatic send_item(input ham_pkg::t_in_item it);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_data = it;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.accept_item(it);
    endtask

    // Hold off the sender until every pending pixel has come out.
    task automatic wait_for_pixels();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [ham_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ham_pkg::CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.set_register(idx, value);
    endtask

    task automatic apply_setup(input logic ham8, input int unsigned pcnt,
                               input int unsigned lw, input int unsigned fh,
                               input int unsigned vw, input int unsigned vh);
        wait_for_pixels();
        write_register(ham_pkg::CFG_HAM8_MODE, ham_pkg::CFG_DAT_W'(ham8));
        write_register(ham_pkg::CFG_PALETTE_COUNT, ham_pkg::CFG_DAT_W'(pcnt));
        write_register(ham_pkg::CFG_LINE_WIDTH, ham_pkg::CFG_DAT_W'(lw));
        write_register(ham_pkg::CFG_FRAME_HEIGHT, ham_pkg::CFG_DAT_W'(fh));
        write_register(ham_pkg::CFG_VISIBLE_WIDTH, ham_pkg::CFG_DAT_W'(vw));
        write_register(ham_pkg::CFG_VISIBLE_HEIGHT, ham_pkg::CFG_DAT_W'(vh));
    endtask

    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 0;
        if (roll == 1) return $urandom_range(ham_pkg::MAX_LINE, 8191);
        return $urandom_range(1, 12);
    endfunction

    function automatic int unsigned pick_visible();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return $urandom_range(ham_pkg::MAX_LINE, 8191);
        return $urandom_range(0, 14);
    endfunction

    function automatic int unsigned pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return ham_pkg::PAL_DEPTH;
        if (roll == 2) return $urandom_range(ham_pkg::PAL_DEPTH + 1, 127);
        return $urandom_range(1, ham_pkg::PAL_DEPTH - 1);
    endfunction

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [ham_pkg::RGB_W-1:0] rgb;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill every palette entry so that no load can hit an unwritten one
        for (int i = 0; i < ham_pkg::PAL_DEPTH; i++) begin
            rgb = ham_pkg::RGB_W'($urandom);
            if (i == 0) rgb = '0;
            if (i == ham_pkg::PAL_DEPTH - 1) rgb = '1;
            send_item(palette_item(6'(i), rgb));
        end

        // HAM6: palette loads, each channel, ignored top bits, row wrap
        apply_setup(1'b0, 16, 4, 3, 3, 2);
        send_item(pixel_item(8'h00));
        send_item(pixel_item(8'h0F));
        send_item(pixel_item(8'h1F));
        send_item(pixel_item(8'h25));
        send_item(pixel_item(8'h3A));
        send_item(pixel_item(8'hC3));
        send_item(pixel_item(8'hFF));
        send_item(pixel_item(8'h10));
        send_item(palette_item(6'd5, 24'h123456));
        send_item(pixel_item(8'h05));
        send_item(pixel_item(8'h2F));

        // degenerate sizes act as one, empty visible area, no palette entries
        apply_setup(1'b1, 0, 0, 0, 0, 0);
        send_item(pixel_item(8'h00));
        send_item(pixel_item(8'h3F));
        send_item(pixel_item(8'h7F));
        send_item(pixel_item(8'hFF));

        // oversized registers saturate
        apply_setup(1'b1, 127, 8191, ham_pkg::MAX_LINE, ham_pkg::MAX_LINE, 8191);
        send_item(pixel_item(8'h3F));
        send_item(pixel_item(8'h40));
        send_item(pixel_item(8'hBF));
        send_item(pixel_item(8'hEA));
        send_item(palette_item(6'd63, 24'h000000));
        send_item(pixel_item(8'h3F));

        // palette count boundary, counters left beyond the new sizes
        apply_setup(1'b1, 20, 5, 2, 5, 1);
        send_item(pixel_item(8'h13));
        send_item(pixel_item(8'h14));
        send_item(pixel_item(8'h15));

        for (int phase = 0; phase < 10; phase++) begin
            apply_setup(1'($urandom_range(0, 1)), pick_count(), pick_size(), pick_size(),
                        pick_visible(), pick_visible());
            idle_on = (phase < 7) ? ($urandom_range(0, 3) != 0) : 1'b0;
            for (int k = 0; k < 175; k++) begin
                if ($urandom_range(0, 99) < 85)
                    send_item(pixel_item(ham_pkg::CODE_W'($urandom)));
                else
                    send_item(palette_item(6'($urandom), ham_pkg::RGB_W'($urandom)));
            end
        end

        idle_on = 1'b0;
        wait_for_pixels();
        if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
